// ===== rtl/core/assert_macros.svh =====
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is high
`define ASSERT_CLK_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check, also active during reset
`define ASSERT_CLK(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/i2cm_pkg.sv =====
// types and constants of the i2c master byte engine
// no dependencies
package i2cm_pkg;

   localparam logic [15:0] HALF_PERIOD_RESET = 16'd10;
   localparam logic [3:0]  BITS_PER_BYTE     = 4'd8;
   localparam int          REQ_TDATA_W       = 16;
   localparam int          RSP_TDATA_W       = 16;

   // command codes on the request channel
   localparam logic [2:0] REQ_START  = 3'd0;
   localparam logic [2:0] REQ_RSTART = 3'd1;
   localparam logic [2:0] REQ_WRITE  = 3'd2;
   localparam logic [2:0] REQ_READ   = 3'd3;
   localparam logic [2:0] REQ_STOP   = 3'd4;

   // running command, request code plus one
   typedef enum logic [2:0] {
      CMD_IDLE   = 3'd0,
      CMD_START  = 3'd1,
      CMD_RSTART = 3'd2,
      CMD_WRITE  = 3'd3,
      CMD_READ   = 3'd4,
      CMD_STOP   = 3'd5
   } cmd_state_type;

   typedef struct packed {
      logic       func;
      logic       sda_level;
      logic       nack_last;
      logic [7:0] data_byte;
      logic [2:0] command;
   } item_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       ack_ok;
      logic       done_res;
      logic       busy_res;
      logic       sda_low;
      logic       scl_low;
   } result_type;

   typedef struct packed {
      logic out_free;
      logic advance;
   } flow_type;

endpackage

// ===== rtl/core/i2cm_in_reg.sv =====
// input register of the i2c master byte engine
// depends on i2cm_pkg
module i2cm_in_reg
   import i2cm_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic                   req_tuser,
   input  logic                   out_free,
   output flow_type               flow,
   output item_type               item
);

   logic     in_valid_ff, in_valid_in;
   item_type item_ff;
   logic     accept;

   assign req_tready    = !in_valid_ff || out_free;
   assign accept        = req_tvalid && req_tready;
   assign flow.out_free = out_free;
   assign flow.advance  = in_valid_ff && out_free;
   assign item          = item_ff;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (flow.advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.func      <= req_tuser;
         item_ff.command   <= req_tdata[2:0];
         item_ff.data_byte <= req_tdata[10:3];
         item_ff.nack_last <= req_tdata[11];
         item_ff.sda_level <= req_tdata[12];
      end
   end

endmodule

// ===== rtl/core/i2cm_engine.sv =====
// bus sequencer: command state, bit timing and next result
// depends on i2cm_pkg
module i2cm_engine
   import i2cm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_we,
   input  logic [15:0] csr_wdata,
   input  flow_type   flow,
   input  item_type   item,
   output result_type result
);

   cmd_state_type cmd_ff, cmd_in;
   logic [3:0]  phase_ff, phase_in;
   logic [3:0]  bit_ff, bit_in;
   logic [7:0]  shift_ff, shift_in;
   logic [15:0] wait_ff, wait_in;
   logic        scl_ff, scl_in;
   logic        sda_ff, sda_in;
   logic        ack_ff, ack_in;
   logic        nack_ff, nack_in;
   logic [7:0]  rx_ff, rx_in;
   logic [15:0] half_period_ff;
   logic        done;

   logic [15:0] wait_inc, len_full, len_half;
   logic        over_full, over_half;
   logic [3:0]  bit_inc;

   assign wait_inc  = wait_ff + 16'd1;
   assign len_full  = (half_period_ff == 16'd0) ? 16'd1 : half_period_ff;
   assign len_half  = (half_period_ff[15:1] == 15'd0) ? 16'd1 : {1'b0, half_period_ff[15:1]};
   assign over_full = (wait_inc >= len_full) || (wait_inc == 16'd0);
   assign over_half = (wait_inc >= len_half) || (wait_inc == 16'd0);
   assign bit_inc   = bit_ff + 4'd1;

   always_comb begin
      cmd_in   = cmd_ff;
      phase_in = phase_ff;
      bit_in   = bit_ff;
      shift_in = shift_ff;
      wait_in  = wait_ff;
      scl_in   = scl_ff;
      sda_in   = sda_ff;
      ack_in   = ack_ff;
      nack_in  = nack_ff;
      rx_in    = rx_ff;
      done     = 1'b0;
      if (item.func) begin
         if (cmd_ff == CMD_IDLE && item.command <= REQ_STOP) begin
            cmd_in   = cmd_state_type'(item.command + 3'd1);
            phase_in = 4'd0;
            bit_in   = 4'd0;
            wait_in  = 16'd0;
            if (item.command != REQ_READ && item.command != REQ_STOP) begin
               shift_in = item.data_byte;
            end
            if (item.command == REQ_READ) begin
               nack_in = item.nack_last;
            end
         end
      end else begin
         unique case (cmd_ff)
            CMD_START: begin
               if (phase_ff == 4'd0) begin
                  sda_in   = 1'b1;
                  phase_in = 4'd1;
               end else if (phase_ff == 4'd1) begin
                  wait_in = over_full ? 16'd0 : wait_inc;
                  if (over_full) phase_in = 4'd2;
               end else begin
                  scl_in   = 1'b1;
                  cmd_in   = CMD_WRITE;
                  phase_in = 4'd0;
                  bit_in   = 4'd0;
               end
            end
            CMD_RSTART: begin
               if (phase_ff == 4'd0) begin
                  sda_in   = 1'b0;
                  phase_in = 4'd1;
               end else if (phase_ff == 4'd1) begin
                  scl_in   = 1'b0;
                  phase_in = 4'd2;
               end else begin
                  wait_in = over_full ? 16'd0 : wait_inc;
                  if (over_full) begin
                     cmd_in   = CMD_START;
                     phase_in = 4'd0;
                  end
               end
            end
            CMD_WRITE: begin
               case (phase_ff)
                  4'd0: begin
                     sda_in   = !shift_ff[7];
                     phase_in = 4'd1;
                  end
                  4'd1: begin
                     scl_in   = 1'b0;
                     phase_in = 4'd2;
                  end
                  4'd2: begin
                     wait_in = over_full ? 16'd0 : wait_inc;
                     if (over_full) phase_in = 4'd3;
                  end
                  4'd3: begin
                     scl_in   = 1'b1;
                     shift_in = {shift_ff[6:0], 1'b0};
                     bit_in   = bit_inc;
                     phase_in = (bit_inc >= BITS_PER_BYTE) ? 4'd4 : 4'd0;
                  end
                  4'd4: begin
                     sda_in   = 1'b0;
                     phase_in = 4'd5;
                  end
                  4'd5: begin
                     scl_in   = 1'b0;
                     phase_in = 4'd6;
                  end
                  4'd6: begin
                     wait_in = over_half ? 16'd0 : wait_inc;
                     if (over_half) begin
                        ack_in   = !item.sda_level;
                        phase_in = 4'd7;
                     end
                  end
                  4'd7: begin
                     scl_in   = 1'b1;
                     phase_in = 4'd8;
                  end
                  4'd8: begin
                     wait_in = over_half ? 16'd0 : wait_inc;
                     if (over_half) phase_in = 4'd9;
                  end
                  default: begin
                     sda_in = 1'b1;
                     done   = 1'b1;
                  end
               endcase
            end
            CMD_READ: begin
               case (phase_ff)
                  4'd0: begin
                     sda_in   = 1'b0;
                     shift_in = 8'd0;
                     bit_in   = 4'd0;
                     phase_in = 4'd1;
                  end
                  4'd1: begin
                     wait_in = over_full ? 16'd0 : wait_inc;
                     if (over_full) phase_in = 4'd2;
                  end
                  4'd2: begin
                     scl_in   = 1'b0;
                     phase_in = 4'd3;
                  end
                  4'd3: begin
                     shift_in = {shift_ff[6:0], item.sda_level};
                     phase_in = 4'd4;
                  end
                  4'd4: begin
                     scl_in = 1'b1;
                     bit_in = bit_inc;
                     if (bit_inc >= BITS_PER_BYTE) begin
                        rx_in    = shift_ff;
                        phase_in = 4'd5;
                     end else begin
                        phase_in = 4'd1;
                     end
                  end
                  4'd5: begin
                     sda_in   = !nack_ff;
                     phase_in = 4'd6;
                  end
                  4'd6: begin
                     scl_in   = 1'b0;
                     phase_in = 4'd7;
                  end
                  4'd7: begin
                     wait_in = over_half ? 16'd0 : wait_inc;
                     if (over_half) phase_in = 4'd8;
                  end
                  4'd8: begin
                     scl_in   = 1'b1;
                     phase_in = 4'd9;
                  end
                  4'd9: begin
                     wait_in = over_half ? 16'd0 : wait_inc;
                     if (over_half) phase_in = 4'd10;
                  end
                  default: begin
                     sda_in = 1'b1;
                     done   = 1'b1;
                  end
               endcase
            end
            CMD_STOP: begin
               case (phase_ff)
                  4'd0: begin
                     sda_in   = 1'b1;
                     phase_in = 4'd1;
                  end
                  4'd1: begin
                     wait_in = over_full ? 16'd0 : wait_inc;
                     if (over_full) phase_in = 4'd2;
                  end
                  4'd2: begin
                     scl_in   = 1'b0;
                     phase_in = 4'd3;
                  end
                  4'd3: begin
                     wait_in = over_full ? 16'd0 : wait_inc;
                     if (over_full) phase_in = 4'd4;
                  end
                  4'd4: begin
                     sda_in   = 1'b0;
                     phase_in = 4'd5;
                  end
                  default: begin
                     wait_in = over_full ? 16'd0 : wait_inc;
                     done    = over_full;
                  end
               endcase
            end
            default: begin
               done = 1'b0;
            end
         endcase
         if (done) begin
            cmd_in   = CMD_IDLE;
            phase_in = 4'd0;
            wait_in  = 16'd0;
         end
      end
      result.scl_low   = scl_in;
      result.sda_low   = sda_in;
      result.busy_res  = (cmd_in != CMD_IDLE);
      result.done_res  = done;
      result.ack_ok    = ack_in;
      result.read_data = rx_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_period_ff <= HALF_PERIOD_RESET;
      end else if (csr_we) begin
         half_period_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_ff   <= CMD_IDLE;
         phase_ff <= 4'd0;
         bit_ff   <= 4'd0;
         shift_ff <= 8'd0;
         wait_ff  <= 16'd0;
         scl_ff   <= 1'b0;
         sda_ff   <= 1'b0;
         ack_ff   <= 1'b0;
         nack_ff  <= 1'b0;
         rx_ff    <= 8'd0;
      end else if (flow.advance) begin
         cmd_ff   <= cmd_in;
         phase_ff <= phase_in;
         bit_ff   <= bit_in;
         shift_ff <= shift_in;
         wait_ff  <= wait_in;
         scl_ff   <= scl_in;
         sda_ff   <= sda_in;
         ack_ff   <= ack_in;
         nack_ff  <= nack_in;
         rx_ff    <= rx_in;
      end
   end

endmodule

// ===== rtl/core/i2cm_out_reg.sv =====
// result register of the i2c master byte engine
// depends on i2cm_pkg
module i2cm_out_reg
   import i2cm_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  flow_type               flow,
   input  result_type             result,
   output logic                   out_free,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   logic       out_valid_ff, out_valid_in;
   result_type result_ff;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - $bits(result_type)){1'b0}}, result_ff};

   always_comb begin
      out_valid_in = out_valid_ff;
      if (flow.advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (flow.advance) begin
         result_ff <= result;
      end
   end

endmodule

// ===== rtl/core/i2c_master_byte_engine_top.sv =====
// top level of the open-drain i2c master byte engine
// depends on i2cm_pkg, i2cm_in_reg, i2cm_engine, i2cm_out_reg
//
// usage:
//   req channel carries one beat per command or bus tick. tuser = 1 issues a
//   command (start, repeated start, write, read, stop) from tdata, tuser = 0
//   is a tick with the sampled sda level that advances the running command.
//   rsp channel returns exactly one beat per request beat: scl/sda drive,
//   busy, done pulse, slave ack and the last read byte.
//   csr_we/csr_wdata set half_period (ticks per full bit delay); write it
//   only while no beat is in flight.
// path: a request beat accepted into the input register is processed by the
//   sequencer into the result register and then shows on rsp. throughput is
//   one beat per cycle while rsp_tready is high, set by the single registered
//   pass through the sequencer.
// reset: synchronous, clears both channel stages, the sequencer (idle, both
//   lines released) and sets half_period to 10.
// stall: while rsp_tready is low the result holds; the input register takes
//   one more beat, then req_tready drops until the result is taken.
module i2c_master_byte_engine_top
   import i2cm_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // command[2:0], data_byte[10:3], nack_last[11], sda_level[12], zero pad
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // func: 1 command, 0 tick
   input  logic                   req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // scl_low[0], sda_low[1], busy_res[2], done_res[3], ack_ok[4],
   // read_data[12:5], zero pad
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   csr_we,
   input  logic [15:0]            csr_wdata
);

   flow_type   flow;
   item_type   item;
   result_type result;
   logic       out_free;

   i2cm_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .out_free   (out_free),
      .flow       (flow),
      .item       (item)
   );

   i2cm_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .flow      (flow),
      .item      (item),
      .result    (result)
   );

   i2cm_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .flow       (flow),
      .result     (result),
      .out_free   (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ===== rtl/core/i2cm_checker.sv =====
// port-level checks of the i2c master byte engine, bound to the top level
// depends on i2cm_pkg, assert_macros.svh
`include "assert_macros.svh"

module i2cm_checker
   import i2cm_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata
);

   logic rsp_stall;
   logic done_busy;

   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign done_busy = rsp_tdata[3] && rsp_tdata[2];

   `ASSERT_CLK(a_reset_empty, clock, reset |=> (!rsp_tvalid && req_tready), "busy after reset")
   `ASSERT_CLK_RST(a_done_not_busy, clock, reset, rsp_tvalid |-> !done_busy, "done with busy")
   `ASSERT_CLK_RST(a_ready_on_stall, clock, reset, !req_tready |-> rsp_stall, "req stalled alone")
   `ASSERT_CLK_RST(a_rsp_keep, clock, reset, rsp_stall |=> rsp_tvalid, "rsp beat dropped")
   `ASSERT_CLK_RST(a_rsp_data, clock, reset, rsp_stall |=> $stable(rsp_tdata), "rsp beat changed")

endmodule

bind i2c_master_byte_engine_top i2cm_checker u_i2cm_checker (.*);
